### hw/rtl/mwu_pkg.sv
// Shared types and constants of the momentum weight update block.
package mwu_pkg;

    localparam int VALUE_W = 16;
    localparam int FRAC_W = 16;
    localparam int CONN_W = 8;
    localparam int PROD_W = 2 * VALUE_W;
    localparam int RATE_SHIFT = 28;
    localparam int MOM_SHIFT = 16;
    localparam int SCALED_W = PROD_W + FRAC_W + 1;
    localparam int T1_W = SCALED_W - RATE_SHIFT;
    localparam int MPROD_W = VALUE_W + FRAC_W + 1;
    localparam int T2_W = MPROD_W - MOM_SHIFT;
    localparam int SUM_W = T1_W + 1;
    localparam int CFG_INDEX_W = 1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_LEARNING_RATE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MOMENTUM = 1'd1;

    localparam logic [FRAC_W-1:0] LEARNING_RATE_RESET = 16'd9830;
    localparam logic [FRAC_W-1:0] MOMENTUM_RESET = 16'd32768;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7fff;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;

    typedef struct packed {
        logic                      mode;
        logic [CONN_W-1:0]         connection;
        logic signed [VALUE_W-1:0] activation;
        logic signed [VALUE_W-1:0] gradient_in;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] new_weight;
        logic signed [VALUE_W-1:0] new_delta;
        logic                      saturated;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic              mode;
        logic              in_range;
        logic [CONN_W-1:0] connection;
    } ctl_t;

endpackage

### hw/rtl/momentum_weight_update.sv
// Top level of the momentum weight update block: configuration, pipeline control and output.
//
// The block takes one request every cycle while the output side keeps up. A request's result
// passes through the pipeline registers in order: the input register, a register after the
// activation-gradient product, one after the rate scaling together with the table read, and
// the output register after the momentum term and write-back. A result waiting at the output
// holds the whole pipeline, input included. Back-to-back updates of one connection are served
// by forwarding the last table write, so no request waits on another. The table is not
// cleared at reset: an entry must be loaded before it is updated. Requests naming a connection
// at or beyond CONNECTIONS leave the table untouched and return zeros. Configuration must be
// written only while idle; the block itself does not enforce this.
module momentum_weight_update #(
    parameter int CONNECTIONS = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  mwu_pkg::req_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mwu_pkg::rsp_t                     out_data,
    input  logic                              cfg_we,
    input  logic [mwu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mwu_pkg::FRAC_W-1:0]        cfg_data
);

    logic [mwu_pkg::FRAC_W-1:0] learning_rate_reg;
    logic [mwu_pkg::FRAC_W-1:0] momentum_reg;
    logic                       out_valid_reg;
    mwu_pkg::rsp_t              out_data_reg;

    logic          advance;
    mwu_pkg::ctl_t rd_ctl;
    mwu_pkg::ctl_t ctl;
    logic signed [mwu_pkg::VALUE_W-1:0] act;
    logic signed [mwu_pkg::T1_W-1:0] t1;
    logic signed [mwu_pkg::VALUE_W-1:0] old_weight;
    logic signed [mwu_pkg::VALUE_W-1:0] old_delta;
    mwu_pkg::rsp_t result;
    logic          upd_wr_en;
    logic signed [mwu_pkg::VALUE_W-1:0] wr_weight;
    logic signed [mwu_pkg::VALUE_W-1:0] wr_delta;

    assign advance = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg <= mwu_pkg::LEARNING_RATE_RESET;
            momentum_reg <= mwu_pkg::MOMENTUM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mwu_pkg::REG_LEARNING_RATE: learning_rate_reg <= cfg_data;
                mwu_pkg::REG_MOMENTUM:      momentum_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    mwu_front #(
        .CONNECTIONS(CONNECTIONS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .advance(advance),
        .in_valid(in_valid),
        .in_data(in_data),
        .learning_rate(learning_rate_reg),
        .rd_ctl(rd_ctl),
        .ctl(ctl),
        .act(act),
        .t1(t1)
    );

    mwu_table #(
        .CONNECTIONS(CONNECTIONS)
    ) u_table (
        .clk(clk),
        .rst_n(rst_n),
        .advance(advance),
        .rd_conn(rd_ctl.connection),
        .wr_en(upd_wr_en && advance),
        .wr_conn(ctl.connection),
        .wr_weight(wr_weight),
        .wr_delta(wr_delta),
        .old_weight(old_weight),
        .old_delta(old_delta)
    );

    mwu_update u_update (
        .ctl(ctl),
        .act(act),
        .t1(t1),
        .old_weight(old_weight),
        .old_delta(old_delta),
        .momentum(momentum_reg),
        .result(result),
        .wr_en(upd_wr_en),
        .wr_weight(wr_weight),
        .wr_delta(wr_delta)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule

### hw/rtl/mwu_front.sv
// Front pipeline: range check, activation times gradient, and scaling by the rate.
module mwu_front #(
    parameter int CONNECTIONS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               in_valid,
    input  mwu_pkg::req_t                      in_data,
    input  logic [mwu_pkg::FRAC_W-1:0]         learning_rate,
    output mwu_pkg::ctl_t                      rd_ctl,
    output mwu_pkg::ctl_t                      ctl,
    output logic signed [mwu_pkg::VALUE_W-1:0] act,
    output logic signed [mwu_pkg::T1_W-1:0]    t1
);

    mwu_pkg::ctl_t ctl1_reg;
    mwu_pkg::ctl_t ctl2_reg;
    mwu_pkg::ctl_t ctl3_reg;
    logic signed [mwu_pkg::VALUE_W-1:0] act1_reg;
    logic signed [mwu_pkg::VALUE_W-1:0] grad1_reg;
    logic signed [mwu_pkg::VALUE_W-1:0] act2_reg;
    logic signed [mwu_pkg::PROD_W-1:0] prod2_reg;
    logic signed [mwu_pkg::VALUE_W-1:0] act3_reg;
    logic signed [mwu_pkg::T1_W-1:0] t1_reg;

    mwu_pkg::ctl_t ctl1_next;
    logic signed [mwu_pkg::PROD_W-1:0] prod2_next;
    logic signed [mwu_pkg::SCALED_W-1:0] scaled;

    always_comb
    begin
        ctl1_next.valid = in_valid;
        ctl1_next.mode = in_data.mode;
        ctl1_next.in_range = 32'(in_data.connection) < 32'(CONNECTIONS);
        ctl1_next.connection = in_data.connection;
        prod2_next = mwu_pkg::PROD_W'(act1_reg) * mwu_pkg::PROD_W'(grad1_reg);
        scaled = mwu_pkg::SCALED_W'(prod2_reg)
            * mwu_pkg::SCALED_W'($signed({1'b0, learning_rate}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (advance)
        begin
            ctl1_reg <= ctl1_next;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            act1_reg <= in_data.activation;
            grad1_reg <= in_data.gradient_in;
            act2_reg <= act1_reg;
            prod2_reg <= prod2_next;
            act3_reg <= act2_reg;
            t1_reg <= scaled[mwu_pkg::SCALED_W-1:mwu_pkg::RATE_SHIFT];
        end
    end

    assign rd_ctl = ctl2_reg;
    assign ctl = ctl3_reg;
    assign act = act3_reg;
    assign t1 = t1_reg;

endmodule

### hw/rtl/mwu_table.sv
// Weight and delta table with write-back forwarding to the following read.
module mwu_table #(
    parameter int CONNECTIONS = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic [mwu_pkg::CONN_W-1:0]         rd_conn,
    input  logic                               wr_en,
    input  logic [mwu_pkg::CONN_W-1:0]         wr_conn,
    input  logic signed [mwu_pkg::VALUE_W-1:0] wr_weight,
    input  logic signed [mwu_pkg::VALUE_W-1:0] wr_delta,
    output logic signed [mwu_pkg::VALUE_W-1:0] old_weight,
    output logic signed [mwu_pkg::VALUE_W-1:0] old_delta
);

    localparam int AW = $clog2(CONNECTIONS);
    localparam int DW = 2 * mwu_pkg::VALUE_W;

    logic [DW-1:0] mem [CONNECTIONS];
    logic [DW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr_reg;
    logic          last_valid_reg;
    logic [AW-1:0] last_addr_reg;
    logic [DW-1:0] last_data_reg;

    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          fwd;

    assign rd_addr = AW'(rd_conn);
    assign wr_addr = AW'(wr_conn);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_weight, wr_delta};
        end
        if (advance)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            last_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            last_addr_reg <= wr_addr;
            last_data_reg <= {wr_weight, wr_delta};
        end
    end

    // The most recent write may not yet be visible in the registered read data.
    assign fwd = last_valid_reg && (last_addr_reg == rd_addr_reg);

    always_comb
    begin
        if (fwd)
        begin
            old_weight = $signed(last_data_reg[DW-1:mwu_pkg::VALUE_W]);
            old_delta = $signed(last_data_reg[mwu_pkg::VALUE_W-1:0]);
        end
        else
        begin
            old_weight = $signed(rd_data_reg[DW-1:mwu_pkg::VALUE_W]);
            old_delta = $signed(rd_data_reg[mwu_pkg::VALUE_W-1:0]);
        end
    end

endmodule

### hw/rtl/mwu_update.sv
// Momentum term, delta and weight sums with saturation, and load handling.
module mwu_update (
    input  mwu_pkg::ctl_t                      ctl,
    input  logic signed [mwu_pkg::VALUE_W-1:0] act,
    input  logic signed [mwu_pkg::T1_W-1:0]    t1,
    input  logic signed [mwu_pkg::VALUE_W-1:0] old_weight,
    input  logic signed [mwu_pkg::VALUE_W-1:0] old_delta,
    input  logic [mwu_pkg::FRAC_W-1:0]         momentum,
    output mwu_pkg::rsp_t                      result,
    output logic                               wr_en,
    output logic signed [mwu_pkg::VALUE_W-1:0] wr_weight,
    output logic signed [mwu_pkg::VALUE_W-1:0] wr_delta
);

    logic signed [mwu_pkg::MPROD_W-1:0] mprod;
    logic signed [mwu_pkg::T2_W-1:0] t2;
    logic signed [mwu_pkg::SUM_W-1:0] dsum;
    logic signed [mwu_pkg::VALUE_W-1:0] d_sat;
    logic signed [mwu_pkg::VALUE_W:0] wsum;
    logic signed [mwu_pkg::VALUE_W-1:0] w_sat;
    logic d_clip;
    logic w_clip;

    always_comb
    begin
        mprod = mwu_pkg::MPROD_W'(old_delta)
            * mwu_pkg::MPROD_W'($signed({1'b0, momentum}));
        t2 = mprod[mwu_pkg::MPROD_W-1:mwu_pkg::MOM_SHIFT];
        dsum = mwu_pkg::SUM_W'(t1) + mwu_pkg::SUM_W'(t2);

        d_clip = 1'b1;
        if (dsum > mwu_pkg::SUM_W'(mwu_pkg::VALUE_MAX))
        begin
            d_sat = mwu_pkg::VALUE_MAX;
        end
        else if (dsum < mwu_pkg::SUM_W'(mwu_pkg::VALUE_MIN))
        begin
            d_sat = mwu_pkg::VALUE_MIN;
        end
        else
        begin
            d_sat = dsum[mwu_pkg::VALUE_W-1:0];
            d_clip = 1'b0;
        end

        wsum = {old_weight[mwu_pkg::VALUE_W-1], old_weight}
            + {d_sat[mwu_pkg::VALUE_W-1], d_sat};
        w_clip = 1'b1;
        if (wsum > (mwu_pkg::VALUE_W + 1)'(mwu_pkg::VALUE_MAX))
        begin
            w_sat = mwu_pkg::VALUE_MAX;
        end
        else if (wsum < (mwu_pkg::VALUE_W + 1)'(mwu_pkg::VALUE_MIN))
        begin
            w_sat = mwu_pkg::VALUE_MIN;
        end
        else
        begin
            w_sat = wsum[mwu_pkg::VALUE_W-1:0];
            w_clip = 1'b0;
        end

        if (ctl.mode == mwu_pkg::MODE_UPDATE)
        begin
            wr_weight = w_sat;
            wr_delta = d_sat;
        end
        else
        begin
            wr_weight = act;
            wr_delta = '0;
        end

        wr_en = ctl.valid && ctl.in_range;

        if (ctl.in_range)
        begin
            result.new_weight = wr_weight;
            result.new_delta = wr_delta;
            result.saturated = (ctl.mode == mwu_pkg::MODE_UPDATE) && (d_clip || w_clip);
        end
        else
        begin
            result = '0;
        end
    end

endmodule
